FILE: sv/saru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scroll address register unit package
// Shared types and operation codes for the scroll and address register set.
// ----------------------------------------------------------------------------
package saru_pkg;

    // Operation codes carried in the operation field of an input item.
    typedef enum logic [3:0] {
        OP_CTRL_WRITE   = 4'd0,
        OP_SCROLL_WRITE = 4'd1,
        OP_ADDR_WRITE   = 4'd2,
        OP_DATA_ACCESS  = 4'd3,
        OP_STATUS_READ  = 4'd4,
        OP_PIXEL        = 4'd5,
        OP_PREFETCH     = 4'd6,
        OP_LINE_END     = 4'd7,
        OP_FRAME_START  = 4'd8
    } t_op;

    // Fixed field values of the address layout.
    localparam logic [2:0] FINE_MAX         = 3'd7;
    localparam logic [4:0] COARSE_X_MAX     = 5'd31;
    localparam logic [4:0] COARSE_Y_LAST    = 5'd29;
    localparam logic [4:0] COARSE_Y_MAX     = 5'd31;
    localparam logic [3:0] ATTR_BASE_HIGH   = 4'hF;
    localparam logic [14:0] ROW_INCREMENT   = 15'd32;
    localparam logic [14:0] COL_INCREMENT   = 15'd1;

    // One input item.
    typedef struct packed {
        logic [3:0] operation;
        logic [7:0] data_byte;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [13:0] vram_address;
        logic [2:0]  fine_x_out;
        logic        toggle_out;
        logic        fetch_valid;
        logic [1:0]  nametable_index;
        logic [9:0]  name_offset;
        logic [9:0]  attribute_offset;
        logic [2:0]  attribute_shift;
        logic [2:0]  fine_y_out;
    } t_out_item;

    // Architectural scroll state.
    typedef struct packed {
        logic [14:0] current_address;
        logic [14:0] temporary_address;
        logic [2:0]  fine_x;
        logic [2:0]  temporary_fine_x;
        logic        write_toggle;
        logic        increment_by_row;
    } t_scroll_state;

endpackage

FILE: sv/saru_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scroll address step logic
// Computes the next scroll state and the result item for one input item.
// ----------------------------------------------------------------------------
module saru_step import saru_pkg::*; (
    input  t_in_item      i_item,
    input  t_scroll_state i_state,
    output t_scroll_state o_state,
    output t_out_item     o_result
);

    // Coarse X increment with horizontal nametable flip.
    function automatic logic [14:0] coarse_x_inc(input logic [14:0] v);
        logic [14:0] r;
        begin
            r = v;
            if (v[4:0] == COARSE_X_MAX) begin
                r[4:0] = 5'd0;
                r[10]  = ~v[10];
            end else begin
                r[4:0] = v[4:0] + 5'd1;
            end
            return r;
        end
    endfunction

    // Fine Y increment carrying into coarse Y with the row-29 wrap.
    function automatic logic [14:0] y_inc(input logic [14:0] v);
        logic [14:0] r;
        begin
            r = v;
            if (v[14:12] == FINE_MAX) begin
                r[14:12] = 3'd0;
                if (v[9:5] == COARSE_Y_LAST) begin
                    r[9:5] = 5'd0;
                    r[11]  = ~v[11];
                end else if (v[9:5] == COARSE_Y_MAX) begin
                    r[9:5] = 5'd0;
                end else begin
                    r[9:5] = v[9:5] + 5'd1;
                end
            end else begin
                r[14:12] = v[14:12] + 3'd1;
            end
            return r;
        end
    endfunction

    t_scroll_state s;
    logic          fetch;
    logic [14:0]   line_addr;
    logic [14:0]   v;
    logic [7:0]    b;

    assign v = i_state.current_address;
    assign b = i_item.data_byte;
    assign line_addr = {v[14:11], i_state.temporary_address[10], v[9:5],
                        i_state.temporary_address[4:0]};

    // Next state per operation.
    always_comb begin
        s     = i_state;
        fetch = 1'b0;
        unique case (i_item.operation)
            OP_CTRL_WRITE: begin
                s.temporary_address[11:10] = b[1:0];
                s.increment_by_row         = b[2];
            end
            OP_SCROLL_WRITE: begin
                s.write_toggle = ~i_state.write_toggle;
                if (!i_state.write_toggle) begin
                    s.temporary_address[4:0] = b[7:3];
                    s.temporary_fine_x       = b[2:0];
                end else begin
                    s.temporary_address[9:5]   = b[7:3];
                    s.temporary_address[14:12] = b[2:0];
                end
            end
            OP_ADDR_WRITE: begin
                s.write_toggle = ~i_state.write_toggle;
                if (!i_state.write_toggle) begin
                    s.temporary_address[14:8] = {1'b0, b[5:0]};
                end else begin
                    s.temporary_address[7:0] = b;
                    s.current_address = {i_state.temporary_address[14:8], b};
                end
            end
            OP_DATA_ACCESS: begin
                s.current_address = v + (i_state.increment_by_row ? ROW_INCREMENT
                                                                  : COL_INCREMENT);
            end
            OP_STATUS_READ: begin
                s.write_toggle = 1'b0;
            end
            OP_PIXEL: begin
                if (i_state.fine_x == FINE_MAX) begin
                    s.fine_x          = 3'd0;
                    fetch             = 1'b1;
                    s.current_address = coarse_x_inc(v);
                end else begin
                    s.fine_x = i_state.fine_x + 3'd1;
                end
            end
            OP_PREFETCH: begin
                fetch             = 1'b1;
                s.current_address = coarse_x_inc(v);
            end
            OP_LINE_END: begin
                s.fine_x          = i_state.temporary_fine_x;
                s.current_address = y_inc(line_addr);
            end
            OP_FRAME_START: begin
                s.current_address = i_state.temporary_address;
                s.fine_x          = i_state.temporary_fine_x;
            end
            default: begin
                s = i_state;
            end
        endcase
    end

    assign o_state = s;

    // Result item; fetch fields come from the address before the coarse X step.
    always_comb begin
        o_result                  = '0;
        o_result.vram_address     = s.current_address[13:0];
        o_result.fine_x_out       = s.fine_x;
        o_result.toggle_out       = s.write_toggle;
        if (fetch) begin
            o_result.fetch_valid      = 1'b1;
            o_result.nametable_index  = v[11:10];
            o_result.name_offset      = v[9:0];
            o_result.attribute_offset = {ATTR_BASE_HIGH, v[9:7], v[4:2]};
            o_result.attribute_shift  = {v[6], v[1], 1'b0};
            o_result.fine_y_out       = v[14:12];
        end
    end

endmodule

FILE: sv/scroll_address_register_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scroll address register unit
// Scroll and address register set of a tile-based video unit: register
// writes, data-port accesses, status reads and render events.
// ----------------------------------------------------------------------------
// Each accepted item produces exactly one result item. An item is captured
// in an input register, evaluated by step logic against the scroll state,
// and its result is held in an output register; one item can be accepted
// every clock cycle while the receiver takes each result. A result enters
// the output register as its item leaves the input register, which waits
// while an untaken result is held. The scroll state is updated as the item
// leaves the input register, so each item sees the effect of the one before
// it. Fetch fields are zero when the item performed no tile fetch.
// ----------------------------------------------------------------------------
module scroll_address_register_unit_top import saru_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic          r_in_valid;
    t_in_item      r_in_item;
    logic          r_out_valid;
    t_out_item     r_out_item;
    t_scroll_state r_state;
    t_scroll_state n_state;
    t_out_item     n_out_item;
    logic          advance;

    // Handshake: the input stage moves on whenever the output register frees.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // Step logic.
    saru_step u_step (
        .i_item   (r_in_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out_item)
    );

    // Scroll state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scroll address register unit testbench
// Drives register writes, data-port accesses, status reads and render events
// into the block, predicts every result item from a local model of the
// scroll state, and compares each returned item field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import saru_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int STALL_LIMIT    = 3000;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 200;

    logic      i_clk;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    // Expected result items, oldest first.
    t_out_item     pending_scroll_results[$];
    // Local copy of the scroll state, updated as items are accepted.
    t_scroll_state scroll_model = '0;

    int   mismatch_count = 0;
    int   stim_count     = 0;
    int   send_idle_pct  = 0;
    int   recv_idle_pct  = 0;
    int   hold_left      = 0;
    int   stall_cycles   = 0;
    logic hold_request   = 1'b0;

    scroll_address_register_unit_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Tile fetch at the current address, then the coarse X step with its
    // horizontal nametable flip.
    function automatic t_out_item fetch_tile();
        t_out_item   fetched;
        logic [14:0] addr;
        fetched                  = '0;
        addr                     = scroll_model.current_address;
        fetched.fetch_valid      = 1'b1;
        fetched.nametable_index  = addr[11:10];
        fetched.name_offset      = addr[9:0];
        fetched.attribute_offset = {ATTR_BASE_HIGH, addr[9:7], addr[4:2]};
        fetched.attribute_shift  = {addr[6], addr[1], 1'b0};
        fetched.fine_y_out       = addr[14:12];
        if (addr[4:0] == COARSE_X_MAX) begin
            addr[4:0] = '0;
            addr[10]  = ~addr[10];
        end else begin
            addr[4:0] = addr[4:0] + 5'd1;
        end
        scroll_model.current_address = addr;
        return fetched;
    endfunction

    // Vertical step: fine Y first, then coarse Y with the row-29 wrap.
    function automatic void advance_row();
        logic [14:0] addr;
        addr = scroll_model.current_address;
        if (addr[14:12] == FINE_MAX) begin
            addr[14:12] = '0;
            if (addr[9:5] == COARSE_Y_LAST) begin
                addr[9:5] = '0;
                addr[11]  = ~addr[11];
            end else if (addr[9:5] == COARSE_Y_MAX) begin
                addr[9:5] = '0;
            end else begin
                addr[9:5] = addr[9:5] + 5'd1;
            end
        end else begin
            addr[14:12] = addr[14:12] + 3'd1;
        end
        scroll_model.current_address = addr;
    endfunction

    // Applies one item to the local scroll state and returns its result.
    function automatic t_out_item predict_scroll_step(input t_in_item item);
        t_out_item res;
        res = '0;
        case (item.operation)
            OP_CTRL_WRITE: begin
                scroll_model.temporary_address[11:10] = item.data_byte[1:0];
                scroll_model.increment_by_row         = item.data_byte[2];
            end
            OP_SCROLL_WRITE: begin
                scroll_model.write_toggle = ~scroll_model.write_toggle;
                if (scroll_model.write_toggle) begin
                    scroll_model.temporary_address[4:0] = item.data_byte[7:3];
                    scroll_model.temporary_fine_x       = item.data_byte[2:0];
                end else begin
                    scroll_model.temporary_address[9:5]   = item.data_byte[7:3];
                    scroll_model.temporary_address[14:12] = item.data_byte[2:0];
                end
            end
            OP_ADDR_WRITE: begin
                scroll_model.write_toggle = ~scroll_model.write_toggle;
                if (scroll_model.write_toggle) begin
                    scroll_model.temporary_address[13:8] = item.data_byte[5:0];
                    scroll_model.temporary_address[14]   = 1'b0;
                end else begin
                    scroll_model.temporary_address[7:0] = item.data_byte;
                    scroll_model.current_address        = scroll_model.temporary_address;
                end
            end
            OP_DATA_ACCESS: begin
                scroll_model.current_address = scroll_model.current_address +
                    (scroll_model.increment_by_row ? ROW_INCREMENT : COL_INCREMENT);
            end
            OP_STATUS_READ: begin
                scroll_model.write_toggle = 1'b0;
            end
            OP_PIXEL: begin
                if (scroll_model.fine_x == FINE_MAX) begin
                    scroll_model.fine_x = '0;
                    res = fetch_tile();
                end else begin
                    scroll_model.fine_x = scroll_model.fine_x + 3'd1;
                end
            end
            OP_PREFETCH: begin
                res = fetch_tile();
            end
            OP_LINE_END: begin
                scroll_model.current_address[4:0] = scroll_model.temporary_address[4:0];
                scroll_model.current_address[10]  = scroll_model.temporary_address[10];
                scroll_model.fine_x               = scroll_model.temporary_fine_x;
                advance_row();
            end
            OP_FRAME_START: begin
                scroll_model.current_address = scroll_model.temporary_address;
                scroll_model.fine_x          = scroll_model.temporary_fine_x;
            end
            default: begin
            end
        endcase
        res.vram_address = scroll_model.current_address[13:0];
        res.fine_x_out   = scroll_model.fine_x;
        res.toggle_out   = scroll_model.write_toggle;
        return res;
    endfunction

    function automatic t_in_item make_item(input logic [3:0] op, input logic [7:0] value);
        t_in_item item;
        item.operation = op;
        item.data_byte = value;
        return item;
    endfunction

    // Counts a mismatch and reports it; output is capped to keep logs short.
    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
        end
    endtask

    // Sends one item, with random idle cycles ahead of it, and records the
    // predicted result once the block accepts it.
    task automatic send_item(input t_in_item item);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        pending_scroll_results.push_back(predict_scroll_step(item));
        if (item.operation <= OP_FRAME_START)
            stim_count++;
    endtask

    // Stops offering items until every expected result has come back.
    task automatic wait_results_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_scroll_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Result receiver: random stalls, plus a long hold when one is requested.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Result checker: each returned item against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_scroll_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual 0x%0h",
                         $time, o_out_item);
            end else begin
                want = pending_scroll_results.pop_front();
                check_field("vram_address", want.vram_address, o_out_item.vram_address);
                check_field("fine_x_out", want.fine_x_out, o_out_item.fine_x_out);
                check_field("toggle_out", want.toggle_out, o_out_item.toggle_out);
                check_field("fetch_valid", want.fetch_valid, o_out_item.fetch_valid);
                check_field("nametable_index", want.nametable_index,
                            o_out_item.nametable_index);
                check_field("name_offset", want.name_offset, o_out_item.name_offset);
                check_field("attribute_offset", want.attribute_offset,
                            o_out_item.attribute_offset);
                check_field("attribute_shift", want.attribute_shift,
                            o_out_item.attribute_shift);
                check_field("fine_y_out", want.fine_y_out, o_out_item.fine_y_out);
            end
        end
    end

    // Watchdog: ends the run when neither side moves an item for too long.
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Control and scroll writes, then data accesses wrapping at 15 bits.
    task automatic test_register_writes();
        send_item(make_item(OP_CTRL_WRITE, 8'hFF));
        send_item(make_item(OP_SCROLL_WRITE, 8'hFF));
        send_item(make_item(OP_SCROLL_WRITE, 8'hFF));
        send_item(make_item(OP_FRAME_START, 8'h00));
        send_item(make_item(OP_DATA_ACCESS, 8'hFF));
        send_item(make_item(OP_CTRL_WRITE, 8'h00));
        send_item(make_item(OP_DATA_ACCESS, 8'h00));
    endtask

    // Address writes with masked high bits, a status read between halves.
    task automatic test_address_writes();
        send_item(make_item(OP_ADDR_WRITE, 8'hFF));
        send_item(make_item(OP_STATUS_READ, 8'hFF));
        send_item(make_item(OP_ADDR_WRITE, 8'hFF));
        send_item(make_item(OP_ADDR_WRITE, 8'hFF));
        send_item(make_item(OP_DATA_ACCESS, 8'h00));
        send_item(make_item(OP_ADDR_WRITE, 8'h00));
        send_item(make_item(OP_ADDR_WRITE, 8'h00));
    endtask

    // Fetches at the right edge, then the row-29 wrap and the row-31 wrap.
    task automatic test_render_walk();
        send_item(make_item(OP_CTRL_WRITE, 8'h03));
        send_item(make_item(OP_SCROLL_WRITE, 8'hFF));
        send_item(make_item(OP_SCROLL_WRITE, 8'hEF));
        send_item(make_item(OP_FRAME_START, 8'h00));
        send_item(make_item(OP_PIXEL, 8'h00));
        send_item(make_item(OP_PREFETCH, 8'h00));
        send_item(make_item(OP_PIXEL, 8'h00));
        send_item(make_item(OP_LINE_END, 8'h00));
        send_item(make_item(OP_SCROLL_WRITE, 8'h00));
        send_item(make_item(OP_SCROLL_WRITE, 8'hFF));
        send_item(make_item(OP_FRAME_START, 8'h00));
        send_item(make_item(OP_LINE_END, 8'h00));
    endtask

    // Codes past the last operation leave the state alone.
    task automatic test_unused_codes();
        send_item(make_item(4'd9, 8'hFF));
        send_item(make_item(4'd15, 8'h00));
    endtask

    // Long receiver hold while items keep coming, then a full drain.
    task automatic test_backpressure();
        int saved_idle;
        saved_idle    = send_idle_pct;
        send_idle_pct = 0;
        hold_request  = 1'b1;
        repeat (24)
            send_item(make_item(4'($urandom_range(8)), 8'($urandom)));
        send_idle_pct = saved_idle;
        wait_results_drained();
    endtask

    // Mostly scanline slices and paired register writes with random content,
    // the rest single random items.
    task automatic test_random_traffic(input int target);
        int         stop_at;
        int         choice;
        int         span;
        logic [3:0] reg_op;
        stop_at = stim_count + target;
        while (stim_count < stop_at) begin
            choice = $urandom_range(99);
            if (choice < 55) begin
                span = $urandom_range(40, 4);
                repeat (span)
                    send_item(make_item(($urandom_range(7) == 0) ? OP_PREFETCH : OP_PIXEL,
                                        8'($urandom)));
                send_item(make_item(OP_LINE_END, 8'($urandom)));
                if ($urandom_range(15) == 0)
                    send_item(make_item(OP_FRAME_START, 8'($urandom)));
            end else if (choice < 80) begin
                if ($urandom_range(1) == 1)
                    send_item(make_item(OP_STATUS_READ, 8'($urandom)));
                if ($urandom_range(3) == 0)
                    send_item(make_item(OP_CTRL_WRITE, 8'($urandom)));
                reg_op = ($urandom_range(1) == 1) ? OP_SCROLL_WRITE : OP_ADDR_WRITE;
                send_item(make_item(reg_op, 8'($urandom)));
                send_item(make_item(reg_op, 8'($urandom)));
                if (reg_op == OP_SCROLL_WRITE && $urandom_range(1) == 1)
                    send_item(make_item(OP_FRAME_START, 8'($urandom)));
            end else begin
                send_item(make_item(4'($urandom_range(15)), 8'($urandom)));
            end
        end
        wait_results_drained();
    endtask

    // Test sequence.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 23;
        recv_idle_pct = 67;
        test_register_writes();
        test_address_writes();
        test_render_walk();
        test_unused_codes();
        test_random_traffic(380);
        test_backpressure();

        send_idle_pct = 67;
        recv_idle_pct = 23;
        test_random_traffic(380);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(380);

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

FILE: files.f
sv/saru_pkg.sv
sv/saru_step.sv
sv/scroll_address_register_unit_top.sv
dv/tb_top.sv
